>>> rtl/cpu8x_pkg.sv
// Shared types, operation codes and flag constants of the 8-bit execute unit.
// No dependencies; the ALU and the execute unit refer to it by scoped names.
package cpu8x_pkg;

   // operation codes, mnemonics in alphabetical order
   localparam logic [5:0] FN_ADC = 6'd0;
   localparam logic [5:0] FN_AND = 6'd1;
   localparam logic [5:0] FN_ASL = 6'd2;
   localparam logic [5:0] FN_BCC = 6'd3;
   localparam logic [5:0] FN_BCS = 6'd4;
   localparam logic [5:0] FN_BEQ = 6'd5;
   localparam logic [5:0] FN_BIT = 6'd6;
   localparam logic [5:0] FN_BMI = 6'd7;
   localparam logic [5:0] FN_BNE = 6'd8;
   localparam logic [5:0] FN_BPL = 6'd9;
   localparam logic [5:0] FN_BRK = 6'd10;
   localparam logic [5:0] FN_BVC = 6'd11;
   localparam logic [5:0] FN_BVS = 6'd12;
   localparam logic [5:0] FN_CLC = 6'd13;
   localparam logic [5:0] FN_CLD = 6'd14;
   localparam logic [5:0] FN_CLI = 6'd15;
   localparam logic [5:0] FN_CLV = 6'd16;
   localparam logic [5:0] FN_CMP = 6'd17;
   localparam logic [5:0] FN_CPX = 6'd18;
   localparam logic [5:0] FN_CPY = 6'd19;
   localparam logic [5:0] FN_DEC = 6'd20;
   localparam logic [5:0] FN_DEX = 6'd21;
   localparam logic [5:0] FN_DEY = 6'd22;
   localparam logic [5:0] FN_EOR = 6'd23;
   localparam logic [5:0] FN_INC = 6'd24;
   localparam logic [5:0] FN_INX = 6'd25;
   localparam logic [5:0] FN_INY = 6'd26;
   localparam logic [5:0] FN_JMP = 6'd27;
   localparam logic [5:0] FN_JSR = 6'd28;
   localparam logic [5:0] FN_LDA = 6'd29;
   localparam logic [5:0] FN_LDX = 6'd30;
   localparam logic [5:0] FN_LDY = 6'd31;
   localparam logic [5:0] FN_LSR = 6'd32;
   localparam logic [5:0] FN_NOP = 6'd33;
   localparam logic [5:0] FN_ORA = 6'd34;
   localparam logic [5:0] FN_PHA = 6'd35;
   localparam logic [5:0] FN_PHP = 6'd36;
   localparam logic [5:0] FN_PLA = 6'd37;
   localparam logic [5:0] FN_PLP = 6'd38;
   localparam logic [5:0] FN_ROL = 6'd39;
   localparam logic [5:0] FN_ROR = 6'd40;
   localparam logic [5:0] FN_RTI = 6'd41;
   localparam logic [5:0] FN_RTS = 6'd42;
   localparam logic [5:0] FN_SBC = 6'd43;
   localparam logic [5:0] FN_SEC = 6'd44;
   localparam logic [5:0] FN_SED = 6'd45;
   localparam logic [5:0] FN_SEI = 6'd46;
   localparam logic [5:0] FN_STA = 6'd47;
   localparam logic [5:0] FN_STX = 6'd48;
   localparam logic [5:0] FN_STY = 6'd49;
   localparam logic [5:0] FN_TAX = 6'd50;
   localparam logic [5:0] FN_TAY = 6'd51;
   localparam logic [5:0] FN_TSX = 6'd52;
   localparam logic [5:0] FN_TXA = 6'd53;
   localparam logic [5:0] FN_TXS = 6'd54;
   localparam logic [5:0] FN_TYA = 6'd55;

   // status bit positions, N V 1 B D I Z C
   localparam int unsigned FLAG_C = 0;
   localparam int unsigned FLAG_Z = 1;
   localparam int unsigned FLAG_I = 2;
   localparam int unsigned FLAG_D = 3;
   localparam int unsigned FLAG_V = 6;
   localparam int unsigned FLAG_N = 7;

   // status byte masks
   localparam logic [7:0] P_PUSH_SET = 8'h30;   // B and bit 5 on a pushed copy
   localparam logic [7:0] P_PULL_KEEP = 8'hCF;  // drop B and bit 5 on a pull
   localparam logic [7:0] P_ALWAYS = 8'h20;     // bit 5 always reads one

   localparam logic [7:0] RESET_SP = 8'hFD;
   localparam logic [7:0] RESET_P = 8'h24;

   typedef struct packed {
      logic [7:0] a;
      logic [7:0] x;
      logic [7:0] y;
      logic [7:0] sp;
      logic [7:0] p;
   } regs_type;

   typedef struct packed {
      regs_type   regs;
      logic       mem_write;
      logic [15:0] mem_address;
      logic [7:0] mem_data;
      logic       pc_load;
      logic [15:0] new_pc;
   } exec_type;

   // update N and Z from a result byte
   function automatic logic [7:0] set_nz(input logic [7:0] p, input logic [7:0] v);
      logic [7:0] q;
      q = p;
      q[FLAG_N] = v[7];
      q[FLAG_Z] = (v == 8'd0);
      return q;
   endfunction

endpackage

>>> rtl/cpu8x_req_if.sv
// Instruction channel: valid/ready handshake carrying one decoded instruction.
// Field widths follow the decoder's item format; no dependencies.
interface cpu8x_req_if;
   logic        valid;
   logic        ready;
   logic [5:0]  func;
   logic [7:0]  operand;
   logic [15:0] target_address;
   logic [15:0] pc_value;
   logic        acc_mode;

   modport source (output valid, func, operand, target_address, pc_value, acc_mode,
                   input ready);
   modport sink (input valid, func, operand, target_address, pc_value, acc_mode,
                 output ready);
endinterface

>>> rtl/cpu8x_rsp_if.sv
// Result channel: valid/ready handshake carrying memory write, PC load and registers.
// No dependencies.
interface cpu8x_rsp_if;
   logic        valid;
   logic        ready;
   logic        mem_write;
   logic [15:0] mem_address;
   logic [7:0]  mem_data;
   logic        pc_load;
   logic [15:0] new_pc;
   logic [7:0]  acc_out;
   logic [7:0]  x_out;
   logic [7:0]  y_out;
   logic [7:0]  sp_out;
   logic [7:0]  flags_out;

   modport source (output valid, mem_write, mem_address, mem_data, pc_load, new_pc,
                   acc_out, x_out, y_out, sp_out, flags_out, input ready);
   modport sink (input valid, mem_write, mem_address, mem_data, pc_load, new_pc,
                 acc_out, x_out, y_out, sp_out, flags_out, output ready);
endinterface

>>> rtl/cpu8x_ram.sv
// Generic single-port RAM with one write or read address per cycle and registered read.
// No dependencies.
module cpu8x_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_en,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   // write, and register the read word
   always_ff @(posedge clock) begin
      if (write_en) begin
         mem_ff[address] <= write_data;
      end
      read_data_ff <= mem_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

>>> rtl/cpu8x_alu.sv
// Combinational execution of every instruction that does not touch the stack store.
// Depends on cpu8x_pkg for operation codes, flag positions and the register struct.
module cpu8x_alu (
   input  cpu8x_pkg::regs_type cur,
   input  logic [5:0]          func,
   input  logic [7:0]          operand,
   input  logic [15:0]         target_address,
   input  logic                acc_mode,
   output cpu8x_pkg::exec_type res
);

   // compare: carry is no borrow, N and Z from the 8-bit difference
   function automatic logic [7:0] compare(input logic [7:0] p, input logic [7:0] r,
                                          input logic [7:0] m);
      logic [8:0] d;
      logic [7:0] q;
      d = {1'b0, r} - {1'b0, m};
      q = cpu8x_pkg::set_nz(p, d[7:0]);
      q[cpu8x_pkg::FLAG_C] = ~d[8];
      return q;
   endfunction

   always_comb begin
      logic [7:0] src;
      logic [7:0] addend;
      logic [7:0] r;
      logic [8:0] sum;
      logic       cin;
      logic       take;

      res = '0;
      res.regs = cur;
      src = acc_mode ? cur.a : operand;
      cin = cur.p[cpu8x_pkg::FLAG_C];
      addend = (func == cpu8x_pkg::FN_SBC) ? ~operand : operand;
      sum = {1'b0, cur.a} + {1'b0, addend} + {8'd0, cin};
      r = '0;
      take = 1'b0;

      case (func) inside
         cpu8x_pkg::FN_ADC, cpu8x_pkg::FN_SBC: begin
            res.regs.a = sum[7:0];
            res.regs.p = cpu8x_pkg::set_nz(cur.p, sum[7:0]);
            res.regs.p[cpu8x_pkg::FLAG_C] = sum[8];
            res.regs.p[cpu8x_pkg::FLAG_V] = ~(cur.a[7] ^ addend[7]) & (cur.a[7] ^ sum[7]);
         end
         cpu8x_pkg::FN_AND: begin
            res.regs.a = cur.a & operand;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.a & operand);
         end
         cpu8x_pkg::FN_EOR: begin
            res.regs.a = cur.a ^ operand;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.a ^ operand);
         end
         cpu8x_pkg::FN_ORA: begin
            res.regs.a = cur.a | operand;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.a | operand);
         end
         cpu8x_pkg::FN_ASL, cpu8x_pkg::FN_LSR, cpu8x_pkg::FN_ROL, cpu8x_pkg::FN_ROR: begin
            if (func == cpu8x_pkg::FN_ASL) begin
               r = {src[6:0], 1'b0};
            end else if (func == cpu8x_pkg::FN_ROL) begin
               r = {src[6:0], cin};
            end else if (func == cpu8x_pkg::FN_LSR) begin
               r = {1'b0, src[7:1]};
            end else begin
               r = {cin, src[7:1]};
            end
            res.regs.p = cpu8x_pkg::set_nz(cur.p, r);
            res.regs.p[cpu8x_pkg::FLAG_C] =
               (func == cpu8x_pkg::FN_ASL || func == cpu8x_pkg::FN_ROL) ? src[7] : src[0];
            if (acc_mode) begin
               res.regs.a = r;
            end else begin
               res.mem_write = 1'b1;
               res.mem_address = target_address;
               res.mem_data = r;
            end
         end
         cpu8x_pkg::FN_BCC: take = ~cur.p[cpu8x_pkg::FLAG_C];
         cpu8x_pkg::FN_BCS: take = cur.p[cpu8x_pkg::FLAG_C];
         cpu8x_pkg::FN_BEQ: take = cur.p[cpu8x_pkg::FLAG_Z];
         cpu8x_pkg::FN_BNE: take = ~cur.p[cpu8x_pkg::FLAG_Z];
         cpu8x_pkg::FN_BMI: take = cur.p[cpu8x_pkg::FLAG_N];
         cpu8x_pkg::FN_BPL: take = ~cur.p[cpu8x_pkg::FLAG_N];
         cpu8x_pkg::FN_BVC: take = ~cur.p[cpu8x_pkg::FLAG_V];
         cpu8x_pkg::FN_BVS: take = cur.p[cpu8x_pkg::FLAG_V];
         cpu8x_pkg::FN_JMP: take = 1'b1;
         cpu8x_pkg::FN_BIT: begin
            res.regs.p[cpu8x_pkg::FLAG_N] = operand[7];
            res.regs.p[cpu8x_pkg::FLAG_V] = operand[6];
            res.regs.p[cpu8x_pkg::FLAG_Z] = ((cur.a & operand) == 8'd0);
         end
         cpu8x_pkg::FN_CLC: res.regs.p[cpu8x_pkg::FLAG_C] = 1'b0;
         cpu8x_pkg::FN_CLD: res.regs.p[cpu8x_pkg::FLAG_D] = 1'b0;
         cpu8x_pkg::FN_CLI: res.regs.p[cpu8x_pkg::FLAG_I] = 1'b0;
         cpu8x_pkg::FN_CLV: res.regs.p[cpu8x_pkg::FLAG_V] = 1'b0;
         cpu8x_pkg::FN_SEC: res.regs.p[cpu8x_pkg::FLAG_C] = 1'b1;
         cpu8x_pkg::FN_SED: res.regs.p[cpu8x_pkg::FLAG_D] = 1'b1;
         cpu8x_pkg::FN_SEI: res.regs.p[cpu8x_pkg::FLAG_I] = 1'b1;
         cpu8x_pkg::FN_CMP: res.regs.p = compare(cur.p, cur.a, operand);
         cpu8x_pkg::FN_CPX: res.regs.p = compare(cur.p, cur.x, operand);
         cpu8x_pkg::FN_CPY: res.regs.p = compare(cur.p, cur.y, operand);
         cpu8x_pkg::FN_DEC, cpu8x_pkg::FN_INC: begin
            r = (func == cpu8x_pkg::FN_DEC) ? operand - 8'd1 : operand + 8'd1;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, r);
            res.mem_write = 1'b1;
            res.mem_address = target_address;
            res.mem_data = r;
         end
         cpu8x_pkg::FN_DEX: begin
            res.regs.x = cur.x - 8'd1;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.x - 8'd1);
         end
         cpu8x_pkg::FN_DEY: begin
            res.regs.y = cur.y - 8'd1;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.y - 8'd1);
         end
         cpu8x_pkg::FN_INX: begin
            res.regs.x = cur.x + 8'd1;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.x + 8'd1);
         end
         cpu8x_pkg::FN_INY: begin
            res.regs.y = cur.y + 8'd1;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.y + 8'd1);
         end
         cpu8x_pkg::FN_LDA: begin
            res.regs.a = operand;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, operand);
         end
         cpu8x_pkg::FN_LDX: begin
            res.regs.x = operand;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, operand);
         end
         cpu8x_pkg::FN_LDY: begin
            res.regs.y = operand;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, operand);
         end
         cpu8x_pkg::FN_STA, cpu8x_pkg::FN_STX, cpu8x_pkg::FN_STY: begin
            res.mem_write = 1'b1;
            res.mem_address = target_address;
            res.mem_data = (func == cpu8x_pkg::FN_STA) ? cur.a :
                           (func == cpu8x_pkg::FN_STX) ? cur.x : cur.y;
         end
         cpu8x_pkg::FN_TAX: begin
            res.regs.x = cur.a;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.a);
         end
         cpu8x_pkg::FN_TAY: begin
            res.regs.y = cur.a;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.a);
         end
         cpu8x_pkg::FN_TSX: begin
            res.regs.x = cur.sp;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.sp);
         end
         cpu8x_pkg::FN_TXA: begin
            res.regs.a = cur.x;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.x);
         end
         cpu8x_pkg::FN_TYA: begin
            res.regs.a = cur.y;
            res.regs.p = cpu8x_pkg::set_nz(cur.p, cur.y);
         end
         cpu8x_pkg::FN_TXS: res.regs.sp = cur.x;
         default: begin
         end
      endcase

      // taken branch or jump
      if (take) begin
         res.pc_load = 1'b1;
         res.new_pc = target_address;
      end
   end

endmodule

>>> rtl/cpu8_instruction_execute.sv
// Instruction execute unit. Takes one decoded instruction per req item and returns
// one rsp item per instruction: optional data write, optional PC load, and A, X, Y,
// SP and status after it. Most instructions finish in the idle state, so items stream
// at one per clock while the result register drains. Stack traffic goes through one
// single-port RAM with registered read, one access per cycle: PHA and PHP end in the
// idle state, JSR and BRK pass the push state, PLA, PLP, RTS and RTI the pop state.
// Per-entry valid bits make the stack read as zero after reset, so no clearing pass.
module cpu8_instruction_execute #(
   parameter int STACK_DEPTH = 256
) (
   input  logic          clock,
   input  logic          reset,
   cpu8x_req_if.sink     req,
   cpu8x_rsp_if.source   rsp
);

   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // pointer to stack entry table, folded at elaboration
   function automatic logic [256*AW-1:0] build_mod_tbl();
      logic [256*AW-1:0] t;
      t = '0;
      for (int i = 0; i < 256; i++) begin
         t[i*AW +: AW] = AW'(i % STACK_DEPTH);
      end
      return t;
   endfunction

   localparam logic [256*AW-1:0] MOD_TBL = build_mod_tbl();

   function automatic logic [AW-1:0] stack_idx(input logic [7:0] s);
      return MOD_TBL[int'(s)*AW +: AW];
   endfunction

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_PUSH = 3'b010,
      ST_POP  = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   cpu8x_pkg::regs_type    regs_ff, regs_in;
   cpu8x_pkg::exec_type    rsp_ff, rsp_in;
   cpu8x_pkg::exec_type    alu_res;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [7:0]             push_ff [2];
   logic [7:0]             push_in [2];
   logic [1:0]             count_ff, count_in;
   logic [1:0]             pops_ff, pops_in;
   logic [5:0]             op_ff, op_in;
   logic [15:0]            tgt_ff, tgt_in;
   logic [7:0]             hold_ff, hold_in;
   logic [STACK_DEPTH-1:0] vld_ff;
   logic                   rd_vld_ff;
   logic                   ram_we;
   logic [AW-1:0]          ram_addr;
   logic [7:0]             ram_wdata;
   logic [7:0]             ram_rdata;
   logic                   accept;
   logic                   out_load;

   cpu8x_alu u_alu (
      .cur            (regs_ff),
      .func           (req.func),
      .operand        (req.operand),
      .target_address (req.target_address),
      .acc_mode       (req.acc_mode),
      .res            (alu_res)
   );

   cpu8x_ram #(
      .WIDTH (8),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock      (clock),
      .write_en   (ram_we),
      .address    (ram_addr),
      .write_data (ram_wdata),
      .read_data  (ram_rdata)
   );

   // take an item when idle and the result register is free or draining
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept = req.valid && req.ready;

   // sequence: ops finished in the idle state, stack pushes, stack pops
   always_comb begin
      logic [15:0] ret;
      logic [7:0]  rd_byte;
      logic [7:0]  sp_up;

      ret = req.pc_value + 16'd2;
      rd_byte = rd_vld_ff ? ram_rdata : 8'd0;
      sp_up = regs_ff.sp + 8'd1;

      state_in = state_ff;
      regs_in = regs_ff;
      push_in = push_ff;
      count_in = count_ff;
      pops_in = pops_ff;
      op_in = op_ff;
      tgt_in = tgt_ff;
      hold_in = hold_ff;
      out_load = 1'b0;
      rsp_in = '0;
      ram_we = 1'b0;
      ram_addr = stack_idx(regs_ff.sp);
      ram_wdata = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in = req.func;
               tgt_in = req.target_address;
               case (req.func) inside
                  cpu8x_pkg::FN_PHA, cpu8x_pkg::FN_PHP: begin
                     ram_we = 1'b1;
                     ram_wdata = (req.func == cpu8x_pkg::FN_PHA) ? regs_ff.a :
                                 (regs_ff.p | cpu8x_pkg::P_PUSH_SET);
                     regs_in.sp = regs_ff.sp - 8'd1;
                     out_load = 1'b1;
                  end
                  cpu8x_pkg::FN_JSR, cpu8x_pkg::FN_BRK: begin
                     ram_we = 1'b1;
                     ram_wdata = ret[15:8];
                     regs_in.sp = regs_ff.sp - 8'd1;
                     push_in[0] = ret[7:0];
                     push_in[1] = regs_ff.p | cpu8x_pkg::P_PUSH_SET;
                     if (req.func == cpu8x_pkg::FN_BRK) begin
                        count_in = 2'd2;
                        regs_in.p[cpu8x_pkg::FLAG_I] = 1'b1;
                     end else begin
                        count_in = 2'd1;
                     end
                     state_in = ST_PUSH;
                  end
                  cpu8x_pkg::FN_PLA, cpu8x_pkg::FN_PLP, cpu8x_pkg::FN_RTS,
                  cpu8x_pkg::FN_RTI: begin
                     regs_in.sp = sp_up;
                     ram_addr = stack_idx(sp_up);
                     pops_in = (req.func == cpu8x_pkg::FN_RTI) ? 2'd2 :
                               (req.func == cpu8x_pkg::FN_RTS) ? 2'd1 : 2'd0;
                     state_in = ST_POP;
                  end
                  default: begin
                     regs_in = alu_res.regs;
                     rsp_in = alu_res;
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         ST_PUSH: begin
            ram_we = 1'b1;
            ram_wdata = push_ff[0];
            regs_in.sp = regs_ff.sp - 8'd1;
            push_in[0] = push_ff[1];
            count_in = count_ff - 2'd1;
            if (count_ff == 2'd1) begin
               rsp_in.pc_load = 1'b1;
               rsp_in.new_pc = tgt_ff;
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_POP: begin
            hold_in = rd_byte;
            // first byte of RTI is the status
            if (op_ff == cpu8x_pkg::FN_RTI && pops_ff == 2'd2) begin
               regs_in.p = (rd_byte & cpu8x_pkg::P_PULL_KEEP) | cpu8x_pkg::P_ALWAYS;
            end
            if (pops_ff != 2'd0) begin
               regs_in.sp = sp_up;
               ram_addr = stack_idx(sp_up);
               pops_in = pops_ff - 2'd1;
            end else begin
               case (op_ff)
                  cpu8x_pkg::FN_PLA: begin
                     regs_in.a = rd_byte;
                     regs_in.p = cpu8x_pkg::set_nz(regs_ff.p, rd_byte);
                  end
                  cpu8x_pkg::FN_PLP: begin
                     regs_in.p = (rd_byte & cpu8x_pkg::P_PULL_KEEP) | cpu8x_pkg::P_ALWAYS;
                  end
                  cpu8x_pkg::FN_RTS: begin
                     rsp_in.pc_load = 1'b1;
                     rsp_in.new_pc = {rd_byte, hold_ff} + 16'd1;
                  end
                  cpu8x_pkg::FN_RTI: begin
                     rsp_in.pc_load = 1'b1;
                     rsp_in.new_pc = {rd_byte, hold_ff};
                  end
                  default: begin
                  end
               endcase
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.regs = regs_in;
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && !rsp.ready);

   // control and architectural registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         regs_ff.a <= 8'd0;
         regs_ff.x <= 8'd0;
         regs_ff.y <= 8'd0;
         regs_ff.sp <= cpu8x_pkg::RESET_SP;
         regs_ff.p <= cpu8x_pkg::RESET_P;
         count_ff <= 2'd0;
         pops_ff <= 2'd0;
         vld_ff <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         regs_ff <= regs_in;
         count_ff <= count_in;
         pops_ff <= pops_in;
         rd_vld_ff <= vld_ff[ram_addr];
         if (ram_we) begin
            vld_ff[ram_addr] <= 1'b1;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      push_ff <= push_in;
      op_ff <= op_in;
      tgt_ff <= tgt_in;
      hold_ff <= hold_in;
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.mem_write = rsp_ff.mem_write;
   assign rsp.mem_address = rsp_ff.mem_address;
   assign rsp.mem_data = rsp_ff.mem_data;
   assign rsp.pc_load = rsp_ff.pc_load;
   assign rsp.new_pc = rsp_ff.new_pc;
   assign rsp.acc_out = rsp_ff.regs.a;
   assign rsp.x_out = rsp_ff.regs.x;
   assign rsp.y_out = rsp_ff.regs.y;
   assign rsp.sp_out = rsp_ff.regs.sp;
   assign rsp.flags_out = rsp_ff.regs.p;

endmodule
